// ===== hdl/mk_pkg.sv =====
package mk_pkg;

	localparam int MaxMessage = 64;
	localparam int AdrW       = $clog2(MaxMessage);
	localparam int CntW       = 7;
	localparam int ElapsedW   = 18;
	localparam int DotW       = 16;
	localparam int CharW      = 8;
	localparam int FuncW      = 2;

	localparam logic [ElapsedW-1:0] ElapsedMax = '1;
	localparam logic [DotW-1:0]     DotReset   = 16'd100;

	localparam logic [FuncW-1:0] FuncTick   = 2'd0;
	localparam logic [FuncW-1:0] FuncAppend = 2'd1;
	localparam logic [FuncW-1:0] FuncStart  = 2'd2;
	localparam logic [FuncW-1:0] FuncStop   = 2'd3;

	typedef enum logic [1:0] {
		OpTick,
		OpAppend,
		OpStart,
		OpStop
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CharW-1:0] char_code;
	} cmd_t;

	// Head of the command queue as seen by the execution side.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	// Bit i of pattern set means symbol i is a dash.
	typedef struct packed {
		logic [2:0] count;
		logic [4:0] pattern;
	} sym_t;

	localparam sym_t CodeRom [36] = '{
		'{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
		'{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
		'{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
		'{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
		'{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
		'{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
		'{3'd4, 5'b01101}, '{3'd4, 5'b00011},
		'{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
		'{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
		'{3'd5, 5'b00111}, '{3'd5, 5'b01111}
	};

	// Letters are case-folded; anything that is not a letter or digit has no symbols.
	function automatic sym_t char_decode(input logic [CharW-1:0] ch);
		logic [CharW-1:0] up;
		sym_t             res;
		up  = ch;
		res = '{3'd0, 5'd0};
		if (ch inside {[8'h61:8'h7A]}) begin
			up = ch - 8'd32;
		end
		if (up inside {[8'h41:8'h5A]}) begin
			res = CodeRom[6'(up - 8'h41)];
		end else if (up inside {[8'h30:8'h39]}) begin
			res = CodeRom[6'(up - 8'h30) + 6'd26];
		end
		return res;
	endfunction

endpackage

// ===== hdl/mk_if.sv =====
interface mk_in_if;
	logic                      valid;
	logic                      ready;
	logic [mk_pkg::FuncW-1:0]  func;
	logic [mk_pkg::CharW-1:0]  char_code;

	modport source(output valid, output func, output char_code, input ready);
	modport sink(input valid, input func, input char_code, output ready);
endinterface

interface mk_out_if;
	logic                     valid;
	logic                     ready;
	logic                     tone_on;
	logic                     busy_res;
	logic [mk_pkg::CntW-1:0]  message_count;
	logic                     status;

	modport source(output valid, output tone_on, output busy_res, output message_count,
		output status, input ready);
	modport sink(input valid, input tone_on, input busy_res, input message_count,
		input status, output ready);
endinterface

// ===== hdl/mk_ram.sv =====
module mk_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mk_front.sv =====
module mk_front (
	input  logic          clk,
	input  logic          arst_n,
	mk_in_if.sink         req,
	input  logic          pop,
	output mk_pkg::head_t head
);

	logic [1:0]   cnt_q;
	logic         wr_q;
	logic         rd_q;
	mk_pkg::cmd_t slot_q [2];
	mk_pkg::cmd_t cmd_in;
	logic         push;

	always_comb begin
		cmd_in.char_code = req.char_code;
		case (req.func)
			mk_pkg::FuncTick:   cmd_in.op = mk_pkg::OpTick;
			mk_pkg::FuncAppend: cmd_in.op = mk_pkg::OpAppend;
			mk_pkg::FuncStart:  cmd_in.op = mk_pkg::OpStart;
			default:            cmd_in.op = mk_pkg::OpStop;
		endcase
	end

	assign req.ready  = (cnt_q != 2'd2);
	assign push       = req.valid && req.ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

endmodule

// ===== hdl/mk_back.sv =====
module mk_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [mk_pkg::DotW-1:0]  cfg_data,
	input  mk_pkg::head_t            head,
	output logic                     pop,
	mk_out_if.source                 rsp
);

	localparam int CntW = mk_pkg::CntW;
	localparam int ElW  = mk_pkg::ElapsedW;

	logic [CntW-1:0]         len_q, len_n;
	logic [CntW-1:0]         cp_q, cp_n, cp_inc;
	logic [4:0]              pat_q, pat_n;
	logic [2:0]              cnt_q, cnt_n;
	logic [2:0]              sp_q, sp_n;
	logic                    tone_q, tone_n;
	logic                    play_q, play_n;
	logic [ElW-1:0]          el_q, el_n, el_inc;
	logic [mk_pkg::DotW-1:0] dot_q;
	logic [mk_pkg::CharW-1:0] first_q, first_n;
	logic                    status_n;
	logic                    mem_we;
	logic [mk_pkg::CharW-1:0] mem_rdata;
	logic [ElW-1:0]          dot_ext, dot3, sym_len;
	logic [7:0]              pat_ext;
	mk_pkg::sym_t            sym_first, sym_next;

	logic                    out_valid_q;
	logic                    tone_out_q, busy_out_q, status_out_q;
	logic [CntW-1:0]         count_out_q;

	assign pop       = head.valid && (!out_valid_q || rsp.ready);
	assign dot_ext   = ElW'(dot_q);
	assign dot3      = {dot_ext[ElW-2:0], 1'b0} + dot_ext;
	assign pat_ext   = {3'b000, pat_q};
	assign sym_len   = pat_ext[sp_q] ? dot3 : dot_ext;
	assign el_inc    = (el_q != mk_pkg::ElapsedMax) ? el_q + 1'b1 : el_q;
	assign cp_inc    = cp_q + 1'b1;
	assign sym_first = mk_pkg::char_decode(first_q);
	assign sym_next  = mk_pkg::char_decode(mem_rdata);

	always_comb begin
		len_n    = len_q;
		cp_n     = cp_q;
		pat_n    = pat_q;
		cnt_n    = cnt_q;
		sp_n     = sp_q;
		tone_n   = tone_q;
		play_n   = play_q;
		el_n     = el_q;
		first_n  = first_q;
		status_n = 1'b0;
		mem_we   = 1'b0;
		if (pop) begin
			case (head.cmd.op)
				mk_pkg::OpTick: begin
					if (play_q) begin
						el_n = el_inc;
						if (tone_q) begin
							if (el_inc >= sym_len) begin
								tone_n = 1'b0;
								sp_n   = sp_q + 1'b1;
								el_n   = '0;
							end
						end else if (sp_q < cnt_q) begin
							if (el_inc >= dot_ext) begin
								tone_n = 1'b1;
								el_n   = '0;
							end
						end else if (el_inc >= dot3) begin
							cp_n = cp_inc;
							// The next character was fetched ahead from the message memory.
							if (cp_inc < len_q && cp_inc < CntW'(mk_pkg::MaxMessage)) begin
								pat_n = sym_next.pattern;
								cnt_n = sym_next.count;
								sp_n  = '0;
							end else begin
								play_n = 1'b0;
							end
							el_n = '0;
						end
					end
				end
				mk_pkg::OpAppend: begin
					if (play_q || len_q >= CntW'(mk_pkg::MaxMessage)) begin
						status_n = 1'b1;
					end else begin
						mem_we = 1'b1;
						len_n  = len_q + 1'b1;
						if (len_q == '0) begin
							first_n = head.cmd.char_code;
						end
					end
				end
				mk_pkg::OpStart: begin
					if (len_q == '0) begin
						play_n = 1'b0;
						tone_n = 1'b0;
					end else begin
						cp_n   = '0;
						pat_n  = sym_first.pattern;
						cnt_n  = sym_first.count;
						sp_n   = '0;
						play_n = 1'b1;
						tone_n = 1'b0;
						el_n   = '0;
					end
				end
				default: begin
					if (!play_q) begin
						len_n = '0;
					end
					play_n = 1'b0;
					tone_n = 1'b0;
				end
			endcase
		end
	end

	// The read port always holds the character after the one now playing.
	mk_ram #(
		.Width(mk_pkg::CharW),
		.Depth(mk_pkg::MaxMessage)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(len_q[mk_pkg::AdrW-1:0]),
		.wdata(head.cmd.char_code),
		.raddr(cp_n[mk_pkg::AdrW-1:0] + 1'b1),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			cp_q        <= '0;
			pat_q       <= '0;
			cnt_q       <= '0;
			sp_q        <= '0;
			tone_q      <= 1'b0;
			play_q      <= 1'b0;
			el_q        <= '0;
			dot_q       <= mk_pkg::DotReset;
			out_valid_q <= 1'b0;
		end else begin
			len_q  <= len_n;
			cp_q   <= cp_n;
			pat_q  <= pat_n;
			cnt_q  <= cnt_n;
			sp_q   <= sp_n;
			tone_q <= tone_n;
			play_q <= play_n;
			el_q   <= el_n;
			if (cfg_we) begin
				dot_q <= cfg_data;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_n;
		if (pop) begin
			tone_out_q   <= tone_n;
			busy_out_q   <= play_n;
			count_out_q  <= len_n;
			status_out_q <= status_n;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.tone_on       = tone_out_q;
	assign rsp.busy_res      = busy_out_q;
	assign rsp.message_count = count_out_q;
	assign rsp.status        = status_out_q;

endmodule

// ===== hdl/morse_keyer_top.sv =====
// Morse keyer: characters are appended to a 64-entry message memory while idle, a start
// item plays the message, and each tick item advances keying time by one unit; every item
// returns one result with the tone, busy flag, message length and append status. The block
// takes one item per clock cycle while the result side is not stalled; a result passes the
// two-entry command queue and then the result register, and either side may stall without
// losing items. The character following the one being played is read ahead from the message
// memory, whose registered read port sets this structure; no clearing pass is needed after
// reset. Write dot_duration only while the block is idle.
module morse_keyer_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [mk_pkg::DotW-1:0]  cfg_data,
	mk_in_if.sink                    req,
	mk_out_if.source                 rsp
);

	mk_pkg::head_t head;
	logic          pop;

	mk_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.pop   (pop),
		.head  (head)
	);

	mk_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.head    (head),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule
